/* rtl/core/dpr_pkg.sv */
// Package for the disparity-to-point reprojection block: field widths,
// register indexes, reset values and the front-to-back job record.
// No dependencies.
package dpr_pkg;

    // Field widths
    localparam int DISP_W  = 16;   // disparity, unsigned Q12.4
    localparam int COORD_W = 12;   // column and row fields
    localparam int FOC_W   = 16;   // focal length, Q12.4
    localparam int BASE_W  = 12;   // baseline in mm
    localparam int SIZE_W  = 13;   // image width and height
    localparam int MAG_W   = 13;   // |2*coord - size|, half pixels
    localparam int PZ_W    = FOC_W + BASE_W;   // F * T
    localparam int PXY_W   = MAG_W + BASE_W;   // |u2| * T
    localparam int NUM_W   = 29;   // rounded numerator fed to the dividers
    localparam int Q_W     = 16;   // quotient bits developed per divider
    localparam int OUT_W   = 16;   // result fields
    localparam int LANES   = 3;    // depth, lateral, vertical

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL  = 3'd0,
        CFG_BASE   = 3'd1,
        CFG_MIN    = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam logic [FOC_W-1:0]  FOCAL_RST  = 16'd8000;
    localparam logic [BASE_W-1:0] BASE_RST   = 12'd120;
    localparam logic [DISP_W-1:0] MIN_RST    = 16'd0;
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Per-pixel flags that ride along with the arithmetic
    typedef struct packed {
        logic pv;      // point valid
        logic last;    // last pixel of frame
        logic neg_x;   // column left of center
        logic neg_y;   // row above center
    } t_side;

    // One classified pixel, products formed, waiting for division
    typedef struct packed {
        logic [PZ_W-1:0]   prod_z;
        logic [PXY_W-1:0]  prod_x;
        logic [PXY_W-1:0]  prod_y;
        logic [DISP_W-1:0] disp;
        t_side             side;
    } t_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

/* rtl/core/dpr_front.sv */
// Front end: configuration registers, input acceptance, pixel classification
// and the products F*T and |u2|*T, |v2|*T. Depends on dpr_pkg.
module dpr_front import dpr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DISP_W-1:0]     i_disp,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic                  i_last,
    input  t_fifo_stat            i_fifo,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam int UsedBits = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] CoordMask = COORD_W'((33'd1 << UsedBits) - 33'd1);

    // Configuration registers
    logic [FOC_W-1:0]  r_focal;
    logic [BASE_W-1:0] r_base;
    logic [DISP_W-1:0] r_min;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= FOCAL_RST;
            r_base   <= BASE_RST;
            r_min    <= MIN_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOCAL:  r_focal  <= i_cfg_wdata[FOC_W-1:0];
                CFG_BASE:   r_base   <= i_cfg_wdata[BASE_W-1:0];
                CFG_MIN:    r_min    <= i_cfg_wdata[DISP_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front stalls as a unit when its last stage cannot hand off
    logic r_a_valid, r_b_valid;
    logic w_en;
    assign w_en    = !r_b_valid || !i_fifo.full;
    assign o_ready = w_en;
    assign o_push  = r_b_valid && !i_fifo.full;

    // Stage A: classify, center offsets in half pixels
    logic [COORD_W-1:0] w_col, w_row;
    logic [SIZE_W-1:0]  w_twice_x, w_twice_y;
    logic               w_neg_x, w_neg_y, w_pv;
    logic [MAG_W-1:0]   w_mag_x, w_mag_y;

    always_comb begin
        w_col     = i_col & CoordMask;
        w_row     = i_row & CoordMask;
        w_twice_x = {w_col, 1'b0};
        w_twice_y = {w_row, 1'b0};
        w_neg_x   = w_twice_x < r_width;
        w_neg_y   = w_twice_y < r_height;
        w_mag_x   = w_neg_x ? (r_width - w_twice_x) : (w_twice_x - r_width);
        w_mag_y   = w_neg_y ? (r_height - w_twice_y) : (w_twice_y - r_height);
        w_pv      = (i_disp != '0) && (i_disp >= r_min);
    end

    logic [DISP_W-1:0] r_a_disp;
    logic [MAG_W-1:0]  r_a_mag_x, r_a_mag_y;
    t_side             r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_disp       <= i_disp;
            r_a_mag_x      <= w_mag_x;
            r_a_mag_y      <= w_mag_y;
            r_a_side.pv    <= w_pv;
            r_a_side.last  <= i_last;
            r_a_side.neg_x <= w_neg_x;
            r_a_side.neg_y <= w_neg_y;
        end
    end

    // Stage B: products
    t_job r_b_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_job.prod_z <= PZ_W'(r_focal) * PZ_W'(r_base);
            r_b_job.prod_x <= PXY_W'(r_a_mag_x) * PXY_W'(r_base);
            r_b_job.prod_y <= PXY_W'(r_a_mag_y) * PXY_W'(r_base);
            r_b_job.disp   <= r_a_disp;
            r_b_job.side   <= r_a_side;
        end
    end

    assign o_job = r_b_job;

endmodule

/* rtl/core/dpr_fifo.sv */
// Short job queue between the front end and the divider back end.
// Flop storage, head read combinationally. Depends on dpr_pkg.
module dpr_fifo import dpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_head,
    output t_fifo_stat o_stat
);

    t_job               r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               w_push, w_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Occupancy
    always_comb begin
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_job;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue occupancy beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not fall on pop");

endmodule

/* rtl/core/dpr_back.sv */
// Back end: rounding bias, saturation check, three pipelined restoring
// dividers (one quotient bit per stage) and result formatting. Depends on dpr_pkg.
module dpr_back import dpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_head,
    input  t_fifo_stat       i_fifo,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_pv,
    output logic [OUT_W-1:0] o_depth,
    output logic [OUT_W-1:0] o_lateral,
    output logic [OUT_W-1:0] o_vertical,
    output logic             o_last
);

    logic r_out_valid;
    logic w_en;

    // Whole back pipeline advances unless the result register is held
    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && !i_fifo.empty;

    // Stage 0: numerators with half-divisor rounding bias
    logic              r0_valid;
    logic [NUM_W-1:0]  r0_num [0:LANES-1];
    logic [DISP_W-1:0] r0_disp;
    t_side             r0_side;
    logic [NUM_W-1:0]  w_bias;

    assign w_bias = NUM_W'(i_head.disp[DISP_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= !i_fifo.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_num[0] <= NUM_W'(i_head.prod_z) + w_bias;
            r0_num[1] <= NUM_W'({i_head.prod_x, 3'b000}) + w_bias;
            r0_num[2] <= NUM_W'({i_head.prod_y, 3'b000}) + w_bias;
            r0_disp   <= i_head.disp;
            r0_side   <= i_head.side;
        end
    end

    // Divider stages: index 0 holds the saturation check, each later index
    // one more quotient bit
    logic              r_valid [0:Q_W];
    logic [DISP_W-1:0] r_disp  [0:Q_W];
    t_side             r_side  [0:Q_W];
    logic              r_sat   [0:Q_W][0:LANES-1];
    logic [Q_W-1:0]    r_rem   [0:Q_W][0:LANES-1];
    logic [Q_W-1:0]    r_low   [0:Q_W][0:LANES-1];
    logic [Q_W-1:0]    r_q     [0:Q_W][0:LANES-1];

    logic [Q_W:0]      w_trial [0:Q_W-1][0:LANES-1];
    logic              w_fit   [0:Q_W-1][0:LANES-1];

    always_comb begin
        for (int s = 0; s < Q_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                w_trial[s][l] = {r_rem[s][l], r_low[s][l][Q_W-1]};
                w_fit[s][l]   = w_trial[s][l] >= {1'b0, r_disp[s]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= Q_W; s++) r_valid[s] <= 1'b0;
        end else if (w_en) begin
            r_valid[0] <= r0_valid;
            for (int s = 1; s <= Q_W; s++) r_valid[s] <= r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // quotient would need more than Q_W bits
            r_disp[0] <= r0_disp;
            r_side[0] <= r0_side;
            for (int l = 0; l < LANES; l++) begin
                r_sat[0][l] <= DISP_W'(r0_num[l][NUM_W-1:Q_W]) >= r0_disp;
                r_rem[0][l] <= Q_W'(r0_num[l][NUM_W-1:Q_W]);
                r_low[0][l] <= r0_num[l][Q_W-1:0];
                r_q[0][l]   <= '0;
            end
            // one restoring step per stage
            for (int s = 0; s < Q_W; s++) begin
                r_disp[s+1] <= r_disp[s];
                r_side[s+1] <= r_side[s];
                for (int l = 0; l < LANES; l++) begin
                    r_sat[s+1][l] <= r_sat[s][l];
                    r_rem[s+1][l] <= w_fit[s][l] ?
                                     Q_W'(w_trial[s][l] - {1'b0, r_disp[s]}) :
                                     w_trial[s][l][Q_W-1:0];
                    r_low[s+1][l] <= {r_low[s][l][Q_W-2:0], 1'b0};
                    r_q[s+1][l]   <= {r_q[s][l][Q_W-2:0], w_fit[s][l]};
                end
            end
        end
    end

    // Result formatting: saturate, apply sign, zero invalid points
    t_side          w_fs;
    logic [OUT_W-1:0] w_depth, w_lat, w_vert;
    logic           w_big_x, w_big_y;
    logic [Q_W-1:0] w_qx, w_qy;

    always_comb begin
        w_fs    = r_side[Q_W];
        w_qx    = r_q[Q_W][1];
        w_qy    = r_q[Q_W][2];
        w_big_x = r_sat[Q_W][1] || w_qx[Q_W-1];
        w_big_y = r_sat[Q_W][2] || w_qy[Q_W-1];
        w_depth = r_sat[Q_W][0] ? '1 : OUT_W'(r_q[Q_W][0]);
        if (w_fs.neg_x) w_lat = w_big_x ? 16'h8000 : OUT_W'(16'd0 - w_qx);
        else            w_lat = w_big_x ? 16'h7FFF : OUT_W'(w_qx);
        if (w_fs.neg_y) w_vert = w_big_y ? 16'h8000 : OUT_W'(16'd0 - w_qy);
        else            w_vert = w_big_y ? 16'h7FFF : OUT_W'(w_qy);
        if (!w_fs.pv) begin
            w_depth = '0;
            w_lat   = '0;
            w_vert  = '0;
        end
    end

    // Result register
    logic             r_out_pv, r_out_last;
    logic [OUT_W-1:0] r_out_depth, r_out_lat, r_out_vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pv    <= w_fs.pv;
            r_out_last  <= w_fs.last;
            r_out_depth <= w_depth;
            r_out_lat   <= w_lat;
            r_out_vert  <= w_vert;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_pv       = r_out_pv;
    assign o_last     = r_out_last;
    assign o_depth    = r_out_depth;
    assign o_lateral  = r_out_lat;
    assign o_vertical = r_out_vert;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_pv) |->
        (r_out_depth == '0 && r_out_lat == '0 && r_out_vert == '0))
        else $error("invalid point carries nonzero coordinates");

endmodule

/* rtl/core/disparity_to_point_reproject.sv */
// Throughput: one pixel per cycle while the result side accepts them; a 16-stage
// divider pipeline (one quotient bit per stage, three lanes) sets the latency.
// A 4-entry queue absorbs output stalls; input requests are taken until the
// queue is full and the last front stage holds a pixel. Reset (synchronous,
// active low) empties pipeline and queue and loads focal 8000, baseline 120,
// min 0, 640 x 480.
module disparity_to_point_reproject import dpr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel requests
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [39:0]           i_s_axis_tdata,   // disparity[15:0], column[27:16], row[39:28]
    input  logic                  i_s_axis_tlast,   // frame_end
    // point requests
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [47:0]           o_m_axis_tdata,   // depth_mm[15:0], lateral_mm[31:16], vertical_mm[47:32]
    output logic                  o_m_axis_tuser,   // point_valid
    output logic                  o_m_axis_tlast    // last_of_frame
);

    logic       w_push, w_pop;
    t_job       w_job, w_head;
    t_fifo_stat w_stat;

    dpr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_disp      (i_s_axis_tdata[15:0]),
        .i_col       (i_s_axis_tdata[27:16]),
        .i_row       (i_s_axis_tdata[39:28]),
        .i_last      (i_s_axis_tlast),
        .i_fifo      (w_stat),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    dpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    dpr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_fifo     (w_stat),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_pv       (o_m_axis_tuser),
        .o_depth    (o_m_axis_tdata[15:0]),
        .o_lateral  (o_m_axis_tdata[31:16]),
        .o_vertical (o_m_axis_tdata[47:32]),
        .o_last     (o_m_axis_tlast)
    );

endmodule

/* sim/disparity_to_point_reproject_test.sv */
// Testbench for disparity_to_point_reproject: directed table, then random phases.
// Results are checked against a local predictor of the reprojection arithmetic.
// Depends on dpr_pkg and the disparity_to_point_reproject RTL.
module disparity_to_point_reproject_test;
    import dpr_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP      = 6;

    // Indexes past the register list; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [DISP_W-1:0]  disp;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_pixel;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] depth;
        logic [OUT_W-1:0] lateral;
        logic [OUT_W-1:0] vertical;
        logic             last;
    } t_point;

    typedef enum logic { STEP_PIXEL, STEP_REG } t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_pixel                pix;
        logic                  typed;   // want holds a hand-computed result
        t_point                want;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [39:0]           i_s_axis_tdata;   // disparity[15:0], column[27:16], row[39:28]
    logic                  i_s_axis_tlast;   // frame_end
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [47:0]           o_m_axis_tdata;   // depth[15:0], lateral[31:16], vertical[47:32]
    logic                  o_m_axis_tuser;   // point_valid
    logic                  o_m_axis_tlast;   // last_of_frame

    // Predictor copy of the register file
    logic [FOC_W-1:0]  focal_q4   = FOCAL_RST;
    logic [BASE_W-1:0] base_mm    = BASE_RST;
    logic [DISP_W-1:0] min_disp   = MIN_RST;
    logic [SIZE_W-1:0] img_width  = WIDTH_RST;
    logic [SIZE_W-1:0] img_height = HEIGHT_RST;

    t_point expected_points[$];
    t_step  directed_steps[$];
    int     mismatch_count = 0;
    logic   tx_steady = 1'b0;   // sender runs without gaps
    logic   rx_steady = 1'b0;   // receiver runs without stalls

    disparity_to_point_reproject dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 600000);
        $display("tb: failure");
        $finish;
    end

    // Nearest integer quotient, ties rounded up
    function automatic logic [63:0] round_quotient(input logic [63:0] num,
                                                   input logic [63:0] den);
        return (num + den / 2) / den;
    endfunction

    // Offset from image center in half pixels, scaled by 8*T/D, saturated to int16
    function automatic logic [OUT_W-1:0] center_offset(input logic [COORD_W-1:0] coord,
                                                       input logic [SIZE_W-1:0]  size,
                                                       input logic [DISP_W-1:0]  disp);
        logic [63:0] twice;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] neg_q;
        logic        neg;
        twice = 64'(coord) * 2;
        neg   = twice < 64'(size);
        mag   = neg ? 64'(size) - twice : twice - 64'(size);
        q     = round_quotient(8 * mag * 64'(base_mm), 64'(disp));
        if (neg) begin
            if (q > 32768)
                q = 32768;
            neg_q = 64'd0 - q;
            return neg_q[OUT_W-1:0];
        end
        if (q > 32767)
            q = 32767;
        return q[OUT_W-1:0];
    endfunction

    function automatic t_point reproject_pixel(input t_pixel p);
        t_point      r;
        logic [63:0] z;
        r      = '0;
        r.last = p.last;
        // zero or sub-minimum disparity: invalid point, fields cleared
        if (p.disp == 0 || p.disp < min_disp)
            return r;
        z = round_quotient(64'(focal_q4) * 64'(base_mm), 64'(p.disp));
        if (z > 65535)
            z = 65535;
        r.valid    = 1'b1;
        r.depth    = z[OUT_W-1:0];
        r.lateral  = center_offset(p.col, img_width, p.disp);
        r.vertical = center_offset(p.row, img_height, p.disp);
        return r;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_step s;
        s.kind    = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        s.pix     = '0;
        s.typed   = 1'b0;
        s.want    = '0;
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    function automatic void add_pixel(input t_pixel p, input logic typed, input t_point want);
        t_step s;
        s.kind    = STEP_PIXEL;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.pix     = p;
        s.typed   = typed;
        s.want    = want;
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_register_value(input int idx);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        case (idx)
            CFG_FOCAL: begin
                if (pick < 8)       v = 1;
                else if (pick < 16) v = 65535;
                else if (pick < 20) v = 0;
                else                v = $urandom_range(1, 65535);
            end
            CFG_BASE: begin
                if (pick < 8)       v = 1;
                else if (pick < 16) v = 4095;
                else if (pick < 20) v = 0;
                else                v = $urandom_range(1, 4095);
                // junk above the field is dropped
                if ($urandom_range(0, 7) == 0)
                    v = v | ($urandom_range(1, 15) << BASE_W);
            end
            CFG_MIN: begin
                if (pick < 50)      v = 0;
                else if (pick < 80) v = $urandom_range(1, 1024);
                else if (pick < 90) v = $urandom_range(0, 65535);
                else                v = 65535;
            end
            default: begin
                // image width or height
                if (pick < 10)      v = 1;
                else if (pick < 20) v = 4096;
                else if (pick < 24) v = 0;
                else if (pick < 28) v = 8191;
                else if (pick < 32) v = $urandom_range(4097, 8191);
                else                v = $urandom_range(64, 4096);
                if ($urandom_range(0, 7) == 0)
                    v = v | ($urandom_range(1, 7) << SIZE_W);
            end
        endcase
        return v[CFG_DATA_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] size);
        int v;
        if (size == 0 || $urandom_range(0, 4) == 0)
            v = $urandom_range(0, 4095);
        else if (size > 4096)
            v = $urandom_range(0, 4095);
        else
            v = $urandom_range(0, size - 1);
        return v[COORD_W-1:0];
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        int     pick;
        int     v;
        pick = $urandom_range(0, 99);
        if (pick < 8)       v = 0;
        else if (pick < 20) v = min_disp + $urandom_range(0, 2) - 1;   // around the threshold
        else if (pick < 30) v = $urandom_range(1, 16);
        else if (pick < 65) v = $urandom_range(1, 1023);
        else                v = $urandom_range(0, 65535);
        p.disp = v[DISP_W-1:0];
        p.col  = pick_coord(img_width);
        p.row  = pick_coord(img_height);
        p.last = ($urandom_range(0, 11) == 0);
        return p;
    endfunction

    // Called at a clock edge; waits until the block is empty, then writes one register
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FOCAL:  focal_q4   = val[FOC_W-1:0];
            CFG_BASE:   base_mm    = val[BASE_W-1:0];
            CFG_MIN:    min_disp   = val[DISP_W-1:0];
            CFG_WIDTH:  img_width  = val[SIZE_W-1:0];
            CFG_HEIGHT: img_height = val[SIZE_W-1:0];
            default: ;  // spare index, ignored
        endcase
    endtask

    // Called at a clock edge; returns at the edge where the request is taken
    task automatic send_pixel(input t_pixel p, input logic typed, input t_point want);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p.row, p.col, p.disp};
        i_s_axis_tlast  <= p.last;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        expected_points.insert(expected_points.size(), typed ? want : reproject_pixel(p));
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // Result side: random stalls, compare each point with the oldest expectation
    initial begin : point_sink
        int     stall;
        t_point got;
        t_point want;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid)
                @(posedge i_clk);
            got = {o_m_axis_tuser, o_m_axis_tdata[15:0], o_m_axis_tdata[31:16],
                   o_m_axis_tdata[47:32], o_m_axis_tlast};
            if (expected_points.size() == 0) begin
                mismatch_count++;
                $display("%0t: point with nothing expected, got %h", $time, got);
            end else begin
                want = expected_points.pop_front();
                check_field("point_valid", OUT_W'(want.valid), OUT_W'(got.valid));
                check_field("depth_mm", want.depth, got.depth);
                check_field("lateral_mm", want.lateral, got.lateral);
                check_field("vertical_mm", want.vertical, got.vertical);
                check_field("last_of_frame", OUT_W'(want.last), OUT_W'(got.last));
            end
        end
    end

    // Pixel side: reset, directed table, random phases, drain
    initial begin : pixel_source
        int                   random_sent;
        int                   count;
        int                   k;
        int                   v;
        logic [CFG_IDX_W-1:0] spare;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        random_sent = 0;

        // Reset defaults: focal 8000, baseline 120, min 0, 640 x 480
        add_pixel({16'd0, 12'd320, 12'd240, 1'b1}, 1'b1,
                  {1'b0, 16'd0, 16'd0, 16'd0, 1'b1});          // zero disparity
        add_pixel({16'd16, 12'd320, 12'd240, 1'b0}, 1'b1,
                  {1'b1, 16'd60000, 16'd0, 16'd0, 1'b0});      // image center
        add_pixel({16'd1, 12'd0, 12'd0, 1'b0}, 1'b1,
                  {1'b1, 16'hFFFF, 16'h8000, 16'h8000, 1'b0}); // all saturate low
        add_pixel({16'd1, 12'd4095, 12'd4095, 1'b1}, 1'b1,
                  {1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1}); // all saturate high
        add_pixel({16'd65535, 12'd4095, 12'd0, 1'b0}, 1'b0, '0);
        add_pixel({16'd960, 12'd100, 12'd400, 1'b0}, 1'b0, '0);
        // Minimum disparity threshold
        add_reg(CFG_MIN, 16'd640);
        add_pixel({16'd639, 12'd10, 12'd20, 1'b1}, 1'b1,
                  {1'b0, 16'd0, 16'd0, 16'd0, 1'b1});
        add_pixel({16'd640, 12'd10, 12'd20, 1'b0}, 1'b0, '0);
        // Zero baseline: valid but all distances zero
        add_reg(CFG_BASE, 16'd0);
        add_pixel({16'd640, 12'd10, 12'd470, 1'b0}, 1'b1,
                  {1'b1, 16'd0, 16'd0, 16'd0, 1'b0});
        // Zero focal length only clears depth
        add_reg(CFG_BASE, 16'd4095);
        add_reg(CFG_FOCAL, 16'd0);
        add_pixel({16'd65535, 12'd0, 12'd4095, 1'b0}, 1'b0, '0);
        add_reg(CFG_FOCAL, 16'd65535);
        add_pixel({16'd65535, 12'd2048, 12'd2048, 1'b1}, 1'b0, '0);
        // Image sizes of zero and past 4096
        add_reg(CFG_WIDTH, 16'd0);
        add_reg(CFG_HEIGHT, 16'd8191);
        add_pixel({16'd1000, 12'd0, 12'd0, 1'b0}, 1'b0, '0);
        add_pixel({16'd777, 12'd4095, 12'd4095, 1'b0}, 1'b0, '0);
        add_reg(CFG_WIDTH, 16'd4096);
        add_reg(CFG_HEIGHT, 16'd1);
        add_reg(CFG_MIN, 16'd65535);
        add_pixel({16'd65534, 12'd2048, 12'd0, 1'b0}, 1'b1,
                  {1'b0, 16'd0, 16'd0, 16'd0, 1'b0});
        add_pixel({16'd65535, 12'd2048, 12'd0, 1'b1}, 1'b0, '0);
        // Spare indexes must not disturb any register
        add_reg(CFG_SPARE_FIRST, 16'd0);
        add_reg(CFG_SPARE_LAST, 16'hFFFF);
        add_pixel({16'd65535, 12'd1000, 12'd3000, 1'b0}, 1'b0, '0);
        // Smallest settings
        add_reg(CFG_MIN, 16'd0);
        add_reg(CFG_FOCAL, 16'd1);
        add_reg(CFG_BASE, 16'd1);
        add_reg(CFG_WIDTH, 16'd1);
        add_pixel({16'd1, 12'd1, 12'd1, 1'b1}, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_REG)
                write_register(directed_steps[i].reg_idx, directed_steps[i].reg_val);
            else
                send_pixel(directed_steps[i].pix, directed_steps[i].typed,
                           directed_steps[i].want);
        end

        // Random phases: new settings while idle, then a burst of pixels
        while (random_sent < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (k = CFG_FOCAL; k <= CFG_HEIGHT; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    spare = k[CFG_IDX_W-1:0];
                    write_register(spare, pick_register_value(k));
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                v     = $urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST);
                spare = v[CFG_IDX_W-1:0];
                v     = $urandom_range(0, 65535);
                write_register(spare, v[CFG_DATA_W-1:0]);
            end
            count = $urandom_range(60, 150);
            // last burst only tops up to the item count
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            repeat (count) begin
                send_pixel(random_pixel(), 1'b0, '0);
                random_sent++;
            end
        end

        // Drain, then allow for anything trailing
        i_s_axis_tvalid <= 1'b0;
        i_cfg_we        <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
